@@ src/sper_pkg.sv @@
// shared types and constants for the shortest-path edge relaxation core
// no dependencies; imported by the controller, datapath, top level and checker

package sper_pkg;

  // distance value that marks a vertex as not reachable
  localparam logic [23:0] UNREACHABLE = 24'd10000000;

  // field widths fixed by the interface
  localparam int VERTEX_BITS = 12;
  localparam int COUNT_BITS  = 13;
  localparam int WEIGHT_PORT = 16;
  localparam int DIST_BITS   = 24;

  // configuration register indexes
  localparam logic REG_VERTEX_COUNT  = 1'b0;
  localparam logic REG_SOURCE_VERTEX = 1'b1;

  // reset value of the vertex count register
  localparam logic [COUNT_BITS-1:0] VERTEX_COUNT_RST = 13'd4096;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_RELAX = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_RD_FROM,
    ST_RD_TO,
    ST_FIN
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture the incoming item
    logic rd_from;    // read the store at the start vertex
    logic rd_to;      // keep the start distance, read the end vertex
    logic init_step;  // write one entry of the init sweep
    logic finish;     // update the store and load the result register
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    action_t action;     // action of the item in flight
    logic    init_done;  // init sweep has covered every vertex in use
    logic    out_free;   // result register can take a new item
  } ctrl_status_t;

endpackage

@@ src/sper_ctrl.sv @@
// sequencer for the relaxation core: init sweep, store reads and result load
// depends on sper_pkg

module sper_ctrl
  import sper_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic [1:0]   action,
  input  ctrl_status_t status,
  output logic         item_stall,
  output ctrl_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load = 1'b1;
          case (action_t'(action))
            ACT_INIT:  state_next = ST_INIT;
            ACT_RELAX: state_next = ST_RD_FROM;
            ACT_READ:  state_next = ST_RD_FROM;
            default:   state_next = ST_FIN;
          endcase
        end
      end
      ST_INIT: begin
        if (status.init_done) begin
          state_next = ST_FIN;
        end else begin
          cmd.init_step = 1'b1;
        end
      end
      ST_RD_FROM: begin
        cmd.rd_from = 1'b1;
        if (status.action == ACT_RELAX) begin
          state_next = ST_RD_TO;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_RD_TO: begin
        cmd.rd_to  = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/sper_dpath.sv @@
// datapath of the relaxation core: config registers, distance store,
// init counter, compare and result register; depends on sper_pkg

module sper_dpath
  import sper_pkg::*;
#(
  parameter int MAX_VERTICES = 4096,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [COUNT_BITS-1:0]  cfg_data,
  input  logic [1:0]             action,
  input  logic [VERTEX_BITS-1:0] from_vertex,
  input  logic [VERTEX_BITS-1:0] to_vertex,
  input  logic [WEIGHT_PORT-1:0] edge_weight,
  input  logic                   last_edge,
  input  ctrl_cmd_t              cmd,
  output ctrl_status_t           status,
  input  logic                   result_stall,
  output logic                   result_valid,
  output logic [DIST_BITS-1:0]   distance,
  output logic                   pass_changed,
  output logic                   pass_end
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = (AW + 1 > COUNT_BITS) ? AW + 1 : COUNT_BITS;
  localparam int WB = (WEIGHT_BITS < WEIGHT_PORT) ? WEIGHT_BITS : WEIGHT_PORT;
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_VERTICES);

  // configuration
  logic [COUNT_BITS-1:0]  vertex_count;
  logic [VERTEX_BITS-1:0] source_vertex;

  // item in flight
  action_t                action_reg;
  logic [VERTEX_BITS-1:0] from_reg;
  logic [VERTEX_BITS-1:0] to_reg;
  logic [WB-1:0]          weight_reg;
  logic                   last_reg;

  // store and read path
  logic [DIST_BITS-1:0] mem [MAX_VERTICES];
  logic [DIST_BITS-1:0] rdata;
  logic [DIST_BITS-1:0] dist_from;
  logic [AW-1:0]        mem_raddr;
  logic                 mem_re;
  logic [AW-1:0]        mem_waddr;
  logic [DIST_BITS-1:0] mem_wdata;
  logic                 mem_we;

  logic [CW-1:0] init_idx;
  logic          changed_flag;

  logic [CW-1:0]        count_eff;
  logic [CW-1:0]        count_ext;
  logic [CW-1:0]        from_ext;
  logic [CW-1:0]        to_ext;
  logic                 from_ok;
  logic                 to_ok;
  logic [DIST_BITS:0]   sum;
  logic                 better;
  logic [DIST_BITS-1:0] dist_res;
  logic                 out_free;

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= VERTEX_COUNT_RST;
      source_vertex <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VERTEX_COUNT:  vertex_count  <= cfg_data;
        REG_SOURCE_VERTEX: source_vertex <= cfg_data[VERTEX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_reg <= action_t'(action);
      from_reg   <= from_vertex;
      to_reg     <= to_vertex;
      weight_reg <= edge_weight[WB-1:0];
      last_reg   <= last_edge;
    end
  end

  // range checks against the vertex count in use
  assign count_ext = CW'(vertex_count);
  assign count_eff = (count_ext > MAX_COUNT) ? MAX_COUNT : count_ext;
  assign from_ext  = CW'(from_reg);
  assign to_ext    = CW'(to_reg);
  assign from_ok   = (from_ext < count_eff);
  assign to_ok     = (to_ext < count_eff);

  // init sweep counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      init_idx <= '0;
    end else if (cmd.init_step) begin
      init_idx <= init_idx + 1'b1;
    end
  end

  // store read port, data registered
  assign mem_re    = cmd.rd_from | cmd.rd_to;
  assign mem_raddr = cmd.rd_from ? from_ext[AW-1:0] : to_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // start distance held while the end vertex is read
  always_ff @(posedge clk) begin
    if (cmd.rd_to) begin
      dist_from <= rdata;
    end
  end

  // relax compare
  assign sum    = {1'b0, dist_from} + (DIST_BITS + 1)'(weight_reg);
  assign better = from_ok && to_ok && (sum < {1'b0, rdata});

  // store write port: init sweep or shorter path
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = init_idx[AW-1:0];
    mem_wdata = (init_idx == CW'(source_vertex)) ? '0 : UNREACHABLE;
    if (cmd.init_step) begin
      mem_we = 1'b1;
    end else if (cmd.finish && action_reg == ACT_RELAX && better) begin
      mem_we    = 1'b1;
      mem_waddr = to_ext[AW-1:0];
      mem_wdata = sum[DIST_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // pass changed flag
  always_ff @(posedge clk) begin
    if (rst) begin
      changed_flag <= 1'b0;
    end else if (cmd.finish) begin
      case (action_reg)
        ACT_INIT:  changed_flag <= 1'b0;
        ACT_RELAX: changed_flag <= last_reg ? 1'b0 : (changed_flag | better);
        default:   changed_flag <= changed_flag;
      endcase
    end
  end

  // result distance per action
  always_comb begin
    case (action_reg)
      ACT_RELAX: dist_res = !to_ok ? UNREACHABLE : (better ? sum[DIST_BITS-1:0] : rdata);
      ACT_READ:  dist_res = from_ok ? rdata : UNREACHABLE;
      default:   dist_res = '0;
    endcase
  end

  // result register
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      distance     <= dist_res;
      pass_end     <= (action_reg == ACT_RELAX) && last_reg;
      pass_changed <= (action_reg == ACT_RELAX) && last_reg && (changed_flag | better);
    end
  end

  // status to the controller
  assign status.action    = action_reg;
  assign status.init_done = (init_idx >= count_eff);
  assign status.out_free  = out_free;

endmodule

@@ src/shortest_path_edge_relaxation_core.sv @@
// top level of the shortest-path edge relaxation core
// depends on sper_pkg, sper_ctrl and sper_dpath
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   action, from_vertex, to_vertex,
//                                                  edge_weight, last_edge
//   result    out        result_valid / result_stall  distance, pass_changed, pass_end
//   config    in         cfg_write                 cfg_index, cfg_data
//
// one item at a time through a distance store with registered reads: relax reads
// the store at the start vertex, then at the end vertex, then compares and writes
// a shorter path back as it loads the result; read does the start-vertex read only,
// an unused action goes straight to the result load, and init writes the store for
// the vertices in use, one store write per cycle. the result register frees the
// item side, so the next item is taken while a result waits under result_stall.
// rst clears the sequencer, config registers, flag and result valid; the store
// holds no defined value until an init item.

module shortest_path_edge_relaxation_core
  import sper_pkg::*;
#(
  parameter int MAX_VERTICES = 4096,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [COUNT_BITS-1:0]  cfg_data,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [1:0]             action,
  input  logic [VERTEX_BITS-1:0] from_vertex,
  input  logic [VERTEX_BITS-1:0] to_vertex,
  input  logic [WEIGHT_PORT-1:0] edge_weight,
  input  logic                   last_edge,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [DIST_BITS-1:0]   distance,
  output logic                   pass_changed,
  output logic                   pass_end
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // sequencer
  sper_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .action     (action),
    .status     (status),
    .item_stall (item_stall),
    .cmd        (cmd)
  );

  // store, compare and result register
  sper_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (action),
    .from_vertex  (from_vertex),
    .to_vertex    (to_vertex),
    .edge_weight  (edge_weight),
    .last_edge    (last_edge),
    .cmd          (cmd),
    .status       (status),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .distance     (distance),
    .pass_changed (pass_changed),
    .pass_end     (pass_end)
  );

endmodule

@@ src/sper_checker.sv @@
// port-level checks for the relaxation core, bound to the top level
// depends on sper_pkg for port widths

module sper_checker
  import sper_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   item_valid,
  input logic                   item_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input logic [DIST_BITS-1:0]   distance,
  input logic                   pass_changed,
  input logic                   pass_end
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // one item at a time: an accepted item blocks the item side next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item side free right after an accept");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(distance) && $stable(pass_end) && $stable(pass_changed)))
    else $error("stalled result changed");

  // the changed flag is only reported when a pass closes
  a_changed_on_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !pass_end) |-> !pass_changed)
    else $error("pass_changed without pass_end");

endmodule

bind shortest_path_edge_relaxation_core sper_checker u_sper_checker (.*);
